// File: design/drts_pkg.sv
// Shared types, constants and the CORDIC angle table of the dead reckoning block.
package drts_pkg;

  // Sizing of the sample counter and the CORDIC loop.
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned MaxSamples  = 1024;
  localparam int unsigned CountW      = 17;
  localparam int unsigned StepW       = 6;

  // Reciprocal of the CORDIC gain in Q2.30.
  localparam logic signed [33:0] GainInv = 34'sd652032874;
  localparam logic signed [33:0] QuarterTurn = 34'sd1073741824;
  localparam logic signed [33:0] HalfTurn    = 34'sd2147483648;

  // One accepted sample as it travels from the front end to the back end.
  typedef struct packed {
    logic signed [15:0] accel;
    logic signed [15:0] temperature;
    logic               first;
    logic               last;
    logic [15:0]        heading;
  } drts_cmd_t;

  // Sequencer states of the back end.
  typedef enum logic [3:0] {
    S_IDLE, S_CORDIC, S_MUL, S_VEL, S_POS, S_SQV, S_LD, S_SQRT,
    S_SPD, S_DST, S_DIVLD, S_DIV, S_MEAN, S_VAR, S_VARCL, S_DONE
  } drts_state_e;

  // Arctangent of 2^-i in units of 2pi/2^32.
  function automatic logic signed [33:0] atan_f(input logic [4:0] idx);
    logic signed [33:0] r;
    case (idx)
      5'd0:  r = 34'sd536870912;
      5'd1:  r = 34'sd316933406;
      5'd2:  r = 34'sd167458907;
      5'd3:  r = 34'sd85004758;
      5'd4:  r = 34'sd42667331;
      5'd5:  r = 34'sd21354465;
      5'd6:  r = 34'sd10679838;
      5'd7:  r = 34'sd5340245;
      5'd8:  r = 34'sd2670163;
      5'd9:  r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: design/drts_if.sv
// Valid/ready channel interfaces for samples and results.
interface drts_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel;
  logic signed [15:0] turn;
  logic signed [15:0] temperature;
  logic               first;
  logic               last;

  modport source (output valid, accel, turn, temperature, first, last, input ready);
  modport sink   (input valid, accel, turn, temperature, first, last, output ready);
endinterface

interface drts_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position_x;
  logic signed [31:0] position_y;
  logic [15:0]        heading;
  logic               stats_valid;
  logic [39:0]        distance_total;
  logic [31:0]        distance_peak;
  logic [31:0]        speed_peak;
  logic signed [15:0] temp_low;
  logic signed [15:0] temp_high;
  logic signed [15:0] temp_mean;
  logic [30:0]        temp_variance;

  modport source (output valid, position_x, position_y, heading, stats_valid,
                  distance_total, distance_peak, speed_peak, temp_low, temp_high,
                  temp_mean, temp_variance, input ready);
  modport sink   (input valid, position_x, position_y, heading, stats_valid,
                  distance_total, distance_peak, speed_peak, temp_low, temp_high,
                  temp_mean, temp_variance, output ready);
endinterface

// File: design/drts_fifo.sv
// Two-entry queue between the front end and the back end.
module drts_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  drts_pkg::drts_cmd_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output drts_pkg::drts_cmd_t pop_data_o,
  output logic              empty_o
);
  import drts_pkg::*;

  drts_cmd_t   mem_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  fill_q;

  assign full_o     = fill_q[1];
  assign empty_o    = (fill_q == 2'd0);
  assign pop_data_o = mem_q[rptr_q];

  // Storage is written at the write pointer.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      if (push_i && !pop_i)      fill_q <= fill_q + 2'd1;
      else if (!push_i && pop_i) fill_q <= fill_q - 2'd1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue read while empty");
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != 2'd3) else $error("queue fill out of range");
endmodule

// File: design/drts_front.sv
// Front end: takes sample beats, tracks the heading and queues the work.
module drts_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  drts_sample_if.sink         sample_i,
  input  logic                full_i,
  output logic                push_o,
  output drts_pkg::drts_cmd_t cmd_o
);
  import drts_pkg::*;

  logic [15:0] heading_q, heading_d;

  assign sample_i.ready = !full_i;
  assign push_o         = sample_i.valid && !full_i;

  // A first beat restarts the heading from zero.
  always_comb begin
    heading_d = sample_i.first ? 16'(sample_i.turn)
                               : heading_q + 16'(sample_i.turn);
  end

  assign cmd_o = '{accel: sample_i.accel, temperature: sample_i.temperature,
                   first: sample_i.first, last: sample_i.last, heading: heading_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_q <= '0;
    end else if (push_o) begin
      heading_q <= heading_d;
    end
  end
endmodule

// File: design/drts_back.sv
// Back end: CORDIC rotation, integration, magnitudes, statistics and result register.
module drts_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  drts_pkg::drts_cmd_t cmd_i,
  output logic                pop_o,
  drts_result_if.source       result_o
);
  import drts_pkg::*;

  drts_state_e state_q, state_d;
  logic [StepW-1:0] cnt_q;
  drts_cmd_t cmd_q;
  logic sel_q, dsel_q, neg_q;

  logic signed [33:0] cx_q, cy_q, cz_q;
  logic signed [49:0] ax_q, ay_q;
  logic signed [31:0] vx_q, vy_q, px_q, py_q;
  logic [63:0] sqa_q, sqb_q, rad_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [31:0] spd_max_q, dst_max_q;
  logic [39:0] dsum_q;
  logic signed [15:0] tmin_q, tmax_q;
  logic signed [31:0] tsum_q;
  logic [47:0] tsq_q;
  logic [CountW-1:0] count_q;
  logic [47:0] dv_q;
  logic [CountW-1:0] drem_q;
  logic signed [16:0] mean_q;
  logic signed [33:0] msq_q;
  logic [30:0] var_q;

  logic out_valid_q;
  logic signed [31:0] o_px_q, o_py_q;
  logic [15:0] o_head_q;
  logic o_stats_q;
  logic [39:0] o_dsum_q;
  logic [31:0] o_dmax_q, o_smax_q;
  logic signed [15:0] o_tmin_q, o_tmax_q, o_mean_q;
  logic [30:0] o_var_q;

  logic out_free, load_out, last_step;
  logic signed [33:0] z0, cos_v, sin_v;
  logic [35:0] sq_r, sq_t;
  logic [CountW:0] dv_r;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647)       return 32'sh7FFFFFFF;
    else if (v < -34'sd2147483648) return 32'sh80000000;
    else                           return v[31:0];
  endfunction

  assign out_free  = !out_valid_q || result_o.ready;
  assign last_step = (cnt_q == StepW'(CordicSteps - 1));
  assign cos_v     = neg_q ? -cx_q : cx_q;
  assign sin_v     = neg_q ? -cy_q : cy_q;
  assign sq_r      = {rem_q, rad_q[63:62]};
  assign sq_t      = {root_q, 2'b01};
  assign dv_r      = {drem_q, dv_q[47]};

  // Angle of the new heading in units of 2pi/2^32; the fold into the right half plane is done on load.
  always_comb begin
    z0 = {{2{cmd_i.heading[15]}}, cmd_i.heading, 16'd0};
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (!empty_i) state_d = S_CORDIC;
      S_CORDIC: if (last_step) state_d = S_MUL;
      S_MUL:    state_d = S_VEL;
      S_VEL:    state_d = S_POS;
      S_POS:    state_d = S_SQV;
      S_SQV:    state_d = S_LD;
      S_LD:     state_d = S_SQRT;
      S_SQRT:   if (cnt_q == StepW'(31)) state_d = sel_q ? S_DST : S_SPD;
      S_SPD:    state_d = S_LD;
      S_DST:    state_d = cmd_q.last ? S_DIVLD : S_DONE;
      S_DIVLD:  state_d = S_DIV;
      S_DIV:    if (cnt_q == StepW'(47)) state_d = dsel_q ? S_VAR : S_MEAN;
      S_MEAN:   state_d = S_DIVLD;
      S_VAR:    state_d = S_VARCL;
      S_VARCL:  state_d = S_DONE;
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    pop_o    = (state_q == S_IDLE) && !empty_i;
    load_out = (state_q == S_DONE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // Datapath and running state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vx_q <= '0; vy_q <= '0; px_q <= '0; py_q <= '0;
      spd_max_q <= '0; dst_max_q <= '0; dsum_q <= '0;
      tmin_q <= '0; tmax_q <= '0; tsum_q <= '0; tsq_q <= '0; count_q <= '0;
      cnt_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            cmd_q <= cmd_i;
            cnt_q <= '0;
            cx_q  <= GainInv;
            cy_q  <= '0;
            if (z0 > QuarterTurn) begin
              cz_q <= z0 - HalfTurn; neg_q <= 1'b1;
            end else if (z0 < -QuarterTurn) begin
              cz_q <= z0 + HalfTurn; neg_q <= 1'b1;
            end else begin
              cz_q <= z0; neg_q <= 1'b0;
            end
            if (cmd_i.first) begin
              vx_q <= '0; vy_q <= '0; px_q <= '0; py_q <= '0;
              spd_max_q <= '0; dst_max_q <= '0; dsum_q <= '0;
              tmin_q <= '0; tmax_q <= '0; tsum_q <= '0; tsq_q <= '0; count_q <= '0;
            end
          end
        end
        S_CORDIC: begin
          // One shift-add rotation step per cycle.
          if (!cz_q[33]) begin
            cx_q <= cx_q - (cy_q >>> cnt_q);
            cy_q <= cy_q + (cx_q >>> cnt_q);
            cz_q <= cz_q - atan_f(cnt_q[4:0]);
          end else begin
            cx_q <= cx_q + (cy_q >>> cnt_q);
            cy_q <= cy_q - (cx_q >>> cnt_q);
            cz_q <= cz_q + atan_f(cnt_q[4:0]);
          end
          cnt_q <= last_step ? '0 : cnt_q + StepW'(1);
        end
        S_MUL: begin
          ax_q <= 50'(cmd_q.accel * cos_v);
          ay_q <= 50'(cmd_q.accel * sin_v);
        end
        S_VEL: begin
          vx_q <= sat32(34'(vx_q) + 34'(ax_q >>> 30));
          vy_q <= sat32(34'(vy_q) + 34'(ay_q >>> 30));
        end
        S_POS: begin
          px_q <= sat32(34'(px_q) + 34'(vx_q));
          py_q <= sat32(34'(py_q) + 34'(vy_q));
        end
        S_SQV: begin
          sqa_q <= 64'(vx_q * vx_q);
          sqb_q <= 64'(vy_q * vy_q);
          sel_q <= 1'b0;
        end
        S_LD: begin
          rad_q  <= sqa_q + sqb_q;
          rem_q  <= '0;
          root_q <= '0;
          cnt_q  <= '0;
        end
        S_SQRT: begin
          // Square root, one result bit per cycle.
          rad_q <= {rad_q[61:0], 2'b00};
          if (sq_r >= sq_t) begin
            rem_q  <= 34'(sq_r - sq_t);
            root_q <= {root_q[30:0], 1'b1};
          end else begin
            rem_q  <= sq_r[33:0];
            root_q <= {root_q[30:0], 1'b0};
          end
          cnt_q <= cnt_q + StepW'(1);
        end
        S_SPD: begin
          if (root_q > spd_max_q) spd_max_q <= root_q;
          dsum_q <= (41'(dsum_q) + 41'(root_q) > 41'h0FFFFFFFFFF) ? '1
                    : dsum_q + 40'(root_q);
          sqa_q  <= 64'(px_q * px_q);
          sqb_q  <= 64'(py_q * py_q);
          sel_q  <= 1'b1;
        end
        S_DST: begin
          if (root_q > dst_max_q) dst_max_q <= root_q;
          // Temperature statistics stop once the count is full.
          if (count_q < CountW'(MaxSamples)) begin
            if (count_q == '0) begin
              tmin_q <= cmd_q.temperature;
              tmax_q <= cmd_q.temperature;
            end else begin
              if (cmd_q.temperature < tmin_q) tmin_q <= cmd_q.temperature;
              if (cmd_q.temperature > tmax_q) tmax_q <= cmd_q.temperature;
            end
            tsum_q  <= tsum_q + 32'(cmd_q.temperature);
            tsq_q   <= tsq_q + 48'(32'(cmd_q.temperature * cmd_q.temperature));
            count_q <= count_q + CountW'(1);
          end
          dsel_q <= 1'b0;
        end
        S_DIVLD: begin
          dv_q   <= dsel_q ? tsq_q : 48'(tsum_q[31] ? -tsum_q : tsum_q);
          drem_q <= '0;
          cnt_q  <= '0;
        end
        S_DIV: begin
          // Restoring division by the sample count, one quotient bit per cycle.
          if (dv_r >= (CountW + 1)'(count_q)) begin
            drem_q <= CountW'(dv_r - (CountW + 1)'(count_q));
            dv_q   <= {dv_q[46:0], 1'b1};
          end else begin
            drem_q <= dv_r[CountW-1:0];
            dv_q   <= {dv_q[46:0], 1'b0};
          end
          cnt_q <= cnt_q + StepW'(1);
        end
        S_MEAN: begin
          if (count_q == '0)  mean_q <= '0;
          else if (tsum_q[31]) mean_q <= -17'(dv_q[16:0]);
          else                 mean_q <= 17'(dv_q[16:0]);
          dsel_q <= 1'b1;
        end
        S_VAR: begin
          msq_q <= 34'(mean_q * mean_q);
        end
        S_VARCL: begin
          if (count_q == '0) var_q <= '0;
          else if ($signed({2'b00, dv_q}) < 50'(msq_q)) var_q <= '0;
          else if ($signed({2'b00, dv_q}) - 50'(msq_q) > 50'sd1073741824)
            var_q <= 31'd1073741824;
          else var_q <= 31'($signed({2'b00, dv_q}) - 50'(msq_q));
        end
        default: ;
      endcase
    end
  end

  // Result register; statistics read as zero on beats that are not last.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      o_px_q    <= px_q;
      o_py_q    <= py_q;
      o_head_q  <= cmd_q.heading;
      o_stats_q <= cmd_q.last;
      o_dsum_q  <= cmd_q.last ? dsum_q : '0;
      o_dmax_q  <= cmd_q.last ? dst_max_q : '0;
      o_smax_q  <= cmd_q.last ? spd_max_q : '0;
      o_tmin_q  <= cmd_q.last ? tmin_q : '0;
      o_tmax_q  <= cmd_q.last ? tmax_q : '0;
      o_mean_q  <= cmd_q.last ? mean_q[15:0] : '0;
      o_var_q   <= cmd_q.last ? var_q : '0;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.position_x     = o_px_q;
  assign result_o.position_y     = o_py_q;
  assign result_o.heading        = o_head_q;
  assign result_o.stats_valid    = o_stats_q;
  assign result_o.distance_total = o_dsum_q;
  assign result_o.distance_peak  = o_dmax_q;
  assign result_o.speed_peak     = o_smax_q;
  assign result_o.temp_low       = o_tmin_q;
  assign result_o.temp_high      = o_tmax_q;
  assign result_o.temp_mean      = o_mean_q;
  assign result_o.temp_variance  = o_var_q;

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == S_CORDIC) else $error("pop did not start rotation");
  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_q && state_q == S_IDLE) else $error("result not loaded");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(MaxSamples)) else $error("sample count past limit");
  a_sqrt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SQRT |-> cnt_q < StepW'(32)) else $error("root step overrun");
endmodule

// File: design/dead_reckoning_telemetry_stats.sv
// Top level of the dead reckoning and telemetry statistics block.
//
//   Port      | Dir | Beat
//   sample_i  | in  | accel, turn, temperature, first, last
//   result_o  | out | position, heading, statistics (zero unless stats_valid)
//
// In the back end a sample passes 16 CORDIC steps and two 32-step square roots,
// and on the last beat also two 48-step divisions. The square roots and the
// divisions are run by one shared sequencer.
// Reset clears all running state at once; no clearing pass is needed.
// Up to two samples queue while the back end works or the result waits.
module dead_reckoning_telemetry_stats (
  input  logic          clk_i,
  input  logic          rst_ni,
  drts_sample_if.sink   sample_i,
  drts_result_if.source result_o
);
  import drts_pkg::*;

  drts_cmd_t push_cmd, pop_cmd;
  logic push, pop, full, empty;

  drts_front u_front (
    .clk_i, .rst_ni, .sample_i, .full_i(full), .push_o(push), .cmd_o(push_cmd)
  );

  drts_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_cmd), .full_o(full),
    .pop_i(pop), .pop_data_o(pop_cmd), .empty_o(empty)
  );

  drts_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .cmd_i(pop_cmd), .pop_o(pop), .result_o
  );
endmodule

// File: dv/drts_test_if.sv
// Testbench package with the type of one expected result beat.
package drts_test_pkg;
  import drts_pkg::*;

  // One expected result beat.
  typedef struct {
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic [15:0]        heading;
    logic               stats_valid;
    logic [39:0]        distance_total;
    logic [31:0]        distance_peak;
    logic [31:0]        speed_peak;
    logic signed [15:0] temp_low;
    logic signed [15:0] temp_high;
    logic signed [15:0] temp_mean;
    logic [30:0]        temp_variance;
  } drts_beat_t;
endpackage

// File: dv/dead_reckoning_telemetry_stats_test.sv
// Self-checking testbench of the dead reckoning and telemetry statistics block.
module dead_reckoning_telemetry_stats_test;
  import drts_pkg::*;
  import drts_test_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  drts_sample_if sample_if ();
  drts_result_if result_if ();

  dead_reckoning_telemetry_stats uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if.sink),
    .result_o (result_if.source)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Motion and statistics state of the predictor.
  logic [15:0]        heading_q;
  logic signed [31:0] vel_x, vel_y, pos_x, pos_y;
  logic [31:0]        speed_top, dist_top;
  logic [39:0]        speed_sum;
  logic signed [15:0] t_min, t_max;
  longint             t_sum;
  longint unsigned    t_sq_sum;
  int unsigned        t_count;

  drts_beat_t expected_beats[$];
  int         error_count = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  bit         hold_off = 1'b0;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] root_of(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r[31:0];
  endfunction

  function automatic logic [31:0] magnitude(logic signed [31:0] x, logic signed [31:0] y);
    longint a, b;
    a = x;
    b = y;
    return root_of(longint'(a * a) + longint'(b * b));
  endfunction

  // Rotate the unit vector to the heading; cosine and sine in Q2.30.
  task automatic rotate_heading(input logic [15:0] h, output longint c, output longint s);
    longint z, x, y, nx, step_angle;
    bit flip;
    z = longint'($signed(h)) * 65536;
    x = GainInv;
    y = 0;
    flip = 1'b0;
    if (z > (64'sd1 <<< 30)) begin
      z -= 64'sd1 <<< 31;
      flip = 1'b1;
    end else if (z < -(64'sd1 <<< 30)) begin
      z += 64'sd1 <<< 31;
      flip = 1'b1;
    end
    for (int i = 0; i < CordicSteps && i < 24; i++) begin
      step_angle = longint'(atan_f(i[4:0]));
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        y  = y + floor_shift(x, i);
        z -= step_angle;
      end else begin
        nx = x + floor_shift(y, i);
        y  = y - floor_shift(x, i);
        z += step_angle;
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic clear_track();
    heading_q = '0;
    vel_x = '0; vel_y = '0; pos_x = '0; pos_y = '0;
    speed_top = '0; dist_top = '0; speed_sum = '0;
    t_min = '0; t_max = '0; t_sum = 0; t_sq_sum = 0; t_count = 0;
  endtask

  // Advance the predictor by one sample and queue the beat it yields.
  task automatic predict_track(input logic signed [15:0] accel, input logic signed [15:0] turn,
                               input logic signed [15:0] temp, input bit first, input bit last);
    longint c, s, mean, var_v;
    logic [31:0] spd, dst;
    longint unsigned sum_wide;
    drts_beat_t b;
    if (first) clear_track();
    heading_q = heading_q + turn;
    rotate_heading(heading_q, c, s);
    vel_x = clamp32(longint'(vel_x) + floor_shift(longint'(accel) * c, 30));
    vel_y = clamp32(longint'(vel_y) + floor_shift(longint'(accel) * s, 30));
    pos_x = clamp32(longint'(pos_x) + longint'(vel_x));
    pos_y = clamp32(longint'(pos_y) + longint'(vel_y));
    spd = magnitude(vel_x, vel_y);
    if (spd > speed_top) speed_top = spd;
    sum_wide = longint'(speed_sum) + spd;
    speed_sum = (sum_wide > 64'hff_ffff_ffff) ? 40'hff_ffff_ffff : sum_wide[39:0];
    dst = magnitude(pos_x, pos_y);
    if (dst > dist_top) dist_top = dst;
    if (t_count < MaxSamples) begin
      if (t_count == 0) begin
        t_min = temp;
        t_max = temp;
      end else begin
        if (temp < t_min) t_min = temp;
        if (temp > t_max) t_max = temp;
      end
      t_sum += temp;
      t_sq_sum += longint'(temp) * longint'(temp);
      t_count++;
    end
    b = '{default: '0};
    b.position_x = pos_x;
    b.position_y = pos_y;
    b.heading = heading_q;
    if (last) begin
      mean = 0;
      var_v = 0;
      if (t_count > 0) begin
        mean = t_sum / longint'(t_count);
        var_v = longint'(t_sq_sum / t_count) - mean * mean;
        if (var_v < 0) var_v = 0;
        if (var_v > (64'sd1 <<< 30)) var_v = 64'sd1 <<< 30;
      end
      b.stats_valid = 1'b1;
      b.distance_total = speed_sum;
      b.distance_peak = dist_top;
      b.speed_peak = speed_top;
      b.temp_low = t_min;
      b.temp_high = t_max;
      b.temp_mean = mean[15:0];
      b.temp_variance = var_v[30:0];
    end
    expected_beats.push_back(b);
  endtask

  // Offer one sample beat, with a random gap, and predict it on acceptance.
  // Valid stays high after acceptance so that beats can follow back to back.
  task automatic send_sample(input logic signed [15:0] accel, input logic signed [15:0] turn,
                             input logic signed [15:0] temp, input bit first, input bit last);
    if ($urandom_range(99) < send_idle_pct) begin
      sample_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    sample_if.valid       <= 1'b1;
    sample_if.accel       <= accel;
    sample_if.turn        <= turn;
    sample_if.temperature <= temp;
    sample_if.first       <= first;
    sample_if.last        <= last;
    do @(posedge clk_i); while (!sample_if.ready);
    predict_track(accel, turn, temp, first, last);
  endtask

  // Receiver readiness, with random stalls and the long hold-off.
  always @(posedge clk_i) begin
    if (hold_off) result_if.ready <= 1'b0;
    else result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk_i) begin
    drts_beat_t e;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected");
        error_count++;
      end else begin
        e = expected_beats.pop_front();
        if (result_if.position_x !== e.position_x) begin
          $error("position_x exp %0d got %0d", e.position_x, result_if.position_x); error_count++;
        end
        if (result_if.position_y !== e.position_y) begin
          $error("position_y exp %0d got %0d", e.position_y, result_if.position_y); error_count++;
        end
        if (result_if.heading !== e.heading) begin
          $error("heading exp %0d got %0d", e.heading, result_if.heading); error_count++;
        end
        if (result_if.stats_valid !== e.stats_valid) begin
          $error("stats_valid exp %0d got %0d", e.stats_valid, result_if.stats_valid);
          error_count++;
        end
        if (result_if.distance_total !== e.distance_total) begin
          $error("distance_total exp %0d got %0d", e.distance_total, result_if.distance_total);
          error_count++;
        end
        if (result_if.distance_peak !== e.distance_peak) begin
          $error("distance_peak exp %0d got %0d", e.distance_peak, result_if.distance_peak);
          error_count++;
        end
        if (result_if.speed_peak !== e.speed_peak) begin
          $error("speed_peak exp %0d got %0d", e.speed_peak, result_if.speed_peak);
          error_count++;
        end
        if (result_if.temp_low !== e.temp_low) begin
          $error("temp_low exp %0d got %0d", e.temp_low, result_if.temp_low); error_count++;
        end
        if (result_if.temp_high !== e.temp_high) begin
          $error("temp_high exp %0d got %0d", e.temp_high, result_if.temp_high); error_count++;
        end
        if (result_if.temp_mean !== e.temp_mean) begin
          $error("temp_mean exp %0d got %0d", e.temp_mean, result_if.temp_mean); error_count++;
        end
        if (result_if.temp_variance !== e.temp_variance) begin
          $error("temp_variance exp %0d got %0d", e.temp_variance, result_if.temp_variance);
          error_count++;
        end
      end
    end
  end

  function automatic logic signed [15:0] any_word();
    return 16'($urandom());
  endfunction

  // Extremes of every field, both flags, turns across the half-turn folds.
  task automatic test_directed();
    send_sample(16'sh7fff, 16'sh0000, 16'sh7fff, 1'b1, 1'b0);
    send_sample(16'sh8000, 16'sh4000, 16'sh8000, 1'b0, 1'b0);
    send_sample(16'sh7fff, 16'sh4001, 16'sh0000, 1'b0, 1'b0);
    send_sample(16'sh7fff, 16'sh3fff, 16'shffff, 1'b0, 1'b0);
    send_sample(16'sh8000, 16'sh8000, 16'sh0100, 1'b0, 1'b0);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, 1'b1);
    // A one-sample run.
    send_sample(16'sh0100, 16'shc000, 16'sh8000, 1'b1, 1'b1);
    // Missing first: statistics carry on from the run before.
    send_sample(16'sh0000, 16'sh0001, 16'sh1234, 1'b0, 1'b1);
    // Full thrust along one heading, then a half turn on the last beat.
    send_sample(16'sh7fff, 16'sh0000, 16'sh0000, 1'b1, 1'b0);
    for (int i = 0; i < 12; i++) send_sample(16'sh7fff, 16'sh0000, 16'sh7fff, 1'b0, 1'b0);
    send_sample(16'sh7fff, 16'sh8000, 16'sh8000, 1'b0, 1'b1);
  endtask

  // Full thrust over a long run past the sample count limit, with periodic half turns.
  task automatic test_long_run();
    send_sample(16'sh7fff, 16'sh0000, any_word(), 1'b1, 1'b0);
    for (int i = 0; i < 1100; i++)
      send_sample(16'sh7fff, (i % 97 == 0) ? 16'sh8000 : 16'sh0000, any_word(), 1'b0,
                  (i % 300) == 299 || i == 1099);
  endtask

  // Short well-formed runs with random content, and some noise.
  task automatic test_random_runs(input int n_items);
    int left, run_len;
    left = n_items;
    while (left > 0) begin
      run_len = $urandom_range(1, 12);
      for (int i = 0; i < run_len && left > 0; i++) begin
        send_sample(($urandom_range(3) == 0) ? any_word() : $signed(16'($urandom_range(0, 1023)) - 16'sd512),
                    any_word(), any_word(),
                    (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0),
                    (i == run_len - 1) ? 1'b1 : ($urandom_range(19) == 0));
        left--;
      end
    end
  endtask

  // Stall the receiver long enough that the input queue fills and blocks.
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (2000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      test_random_runs(8);
    join
  endtask

  initial begin
    sample_if.valid = 1'b0;
    sample_if.accel = '0;
    sample_if.turn = '0;
    sample_if.temperature = '0;
    sample_if.first = 1'b0;
    sample_if.last = 1'b0;
    clear_track();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 10; recv_idle_pct = 79;
    test_directed();
    test_random_runs(100);
    send_idle_pct = 79; recv_idle_pct = 10;
    test_random_runs(100);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_backpressure();
    test_random_runs(100);
    test_long_run();
    sample_if.valid <= 1'b0;
    wait (expected_beats.size() == 0);
    repeat (400) @(posedge clk_i);
    if (error_count == 0 && expected_beats.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end
endmodule
